// ===== src/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants of the contiguous frame allocator
// Command, frame state and status codes, queue entry and engine state types.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int FRM_W = 20;   // absolute frame number
   localparam int CNT_W = 15;   // frame counts and pool size
   localparam int REL_W = 16;   // frame offset inside the pool
   localparam int CMP_W = 17;   // offset arithmetic with headroom
   localparam int IDX_W = 2;    // register index
   localparam int SPR   = 32;   // frame states per memory row
   localparam int GRP   = 8;    // frames examined per scan step

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_MARK    = 2'd2;
   localparam logic [1:0] MODE_CLEAR   = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NORUN   = 2'd1;
   localparam logic [1:0] STAT_NOTHEAD = 2'd2;
   localparam logic [1:0] STAT_RANGE   = 2'd3;

   localparam logic [1:0] FS_USED = 2'b00;
   localparam logic [1:0] FS_HEAD = 2'b10;
   localparam logic [1:0] FS_FREE = 2'b11;

   localparam logic [IDX_W-1:0] REG_BASE = 2'd0;
   localparam logic [IDX_W-1:0] REG_POOL = 2'd1;

   typedef enum logic [2:0] {
      OP_ALLOC, OP_RELEASE, OP_MARK, OP_CLEAR, OP_REJECT
   } cfa_op_type;

   typedef struct packed {
      cfa_op_type        op;
      logic [REL_W-1:0]  rel;
      logic [CNT_W-1:0]  cnt;
   } cfa_cmd_type;

   typedef struct packed {
      logic        valid;
      cfa_cmd_type cmd;
   } cfa_qhead_type;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_DISP, S_A_RD, S_A_SCAN, S_W_RD, S_W_WR, S_R_RD, S_R_CHK, S_DONE
   } cfa_state_type;

endpackage

// ===== src/cfa_ifs.sv =====
// ----------------------------------------------------------------------------
// cfa_ifs: request and response channels of the frame allocator
// Valid/ready channels carrying one command word and one response word.
// ----------------------------------------------------------------------------
interface cfa_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic [cfa_pkg::FRM_W-1:0] frame_num;
   logic [cfa_pkg::CNT_W-1:0] count;
   modport source (output valid, mode, frame_num, count, input ready);
   modport sink   (input valid, mode, frame_num, count, output ready);
endinterface

interface cfa_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [cfa_pkg::FRM_W-1:0] first_frame;
   logic [cfa_pkg::CNT_W-1:0] free_count;
   modport source (output valid, status, first_frame, free_count, input ready);
   modport sink   (input valid, status, first_frame, free_count, output ready);
endinterface

// ===== src/contiguous_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_unit: first-fit contiguous frame allocator
// Two-bit state per frame in a 32-frames-per-row memory, one pool.
// ----------------------------------------------------------------------------
//  channel   kind          word
//  req_bus   valid/ready   mode, frame_num, count
//  rsp_bus   valid/ready   status, first_frame, free_count
//  csr_*     write only    index 0 base_frame, index 1 pool_frames
//
//  Every command passes through pop, dispatch and completion. In between, allocate
//  reads and scans each row group by group until a run is found, then reads and
//  writes each row of the run; release and mark read and write each row touched;
//  clear writes each row. The memory port reaches one row per access.
//  After reset, after a pool_frames write and on a clear command a sweep clears
//  the memory row by row; no request word is taken meanwhile.
//  A two-word queue and an output register let both sides stall on their own.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_unit #(
   parameter int MAX_FRAMES = 16384
) (
   input  logic                      clock,
   input  logic                      reset,
   cfa_req_if.sink                   req_bus,
   cfa_rsp_if.source                 rsp_bus,
   input  logic                      csr_we,
   input  logic [cfa_pkg::IDX_W-1:0] csr_index,
   input  logic [cfa_pkg::FRM_W-1:0] csr_wdata
);
   import cfa_pkg::*;

   logic [FRM_W-1:0] base_ff;
   logic [CNT_W-1:0] pool_ff;
   logic [CNT_W-1:0] pool_n;
   logic             clear_trig;
   logic             busy;
   logic             q_ready;
   logic             push;
   logic             pop;
   cfa_cmd_type      push_cmd;
   cfa_qhead_type    head;

   assign pool_n = (CMP_W'(pool_ff) > CMP_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : pool_ff;
   assign clear_trig = csr_we && (csr_index == REG_POOL);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         pool_ff <= CNT_W'(16384);
      end else if (csr_we) begin
         case (csr_index)
            REG_BASE: base_ff <= csr_wdata;
            REG_POOL: pool_ff <= csr_wdata[CNT_W-1:0];
            default:  ;
         endcase
      end
   end

   cfa_front u_front (
      .req_bus    (req_bus),
      .base_frame (base_ff),
      .pool_n     (pool_n),
      .busy       (busy),
      .q_ready    (q_ready),
      .push       (push),
      .cmd        (push_cmd)
   );

   cfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .q_ready  (q_ready),
      .pop      (pop),
      .head     (head)
   );

   cfa_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .busy       (busy),
      .base_frame (base_ff),
      .pool_n     (pool_n),
      .clear_trig (clear_trig),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== src/cfa_front.sv =====
// ----------------------------------------------------------------------------
// cfa_front: command intake and classification
// Checks range and count of each request word as its mode needs and turns it into an engine op.
// ----------------------------------------------------------------------------
module cfa_front (
   cfa_req_if.sink                   req_bus,
   input  logic [cfa_pkg::FRM_W-1:0] base_frame,
   input  logic [cfa_pkg::CNT_W-1:0] pool_n,
   input  logic                      busy,
   input  logic                      q_ready,
   output logic                      push,
   output cfa_pkg::cfa_cmd_type      cmd
);
   import cfa_pkg::*;

   logic [FRM_W-1:0] rel;
   logic [FRM_W-1:0] n_ext;
   logic             below;
   logic             outside;
   logic             zero_cnt;
   logic             too_long;

   assign req_bus.ready = q_ready && !busy;
   assign push          = req_bus.valid && req_bus.ready;

   assign rel      = req_bus.frame_num - base_frame;
   assign n_ext    = FRM_W'(pool_n);
   assign below    = req_bus.frame_num < base_frame;
   assign outside  = below || (rel >= n_ext);
   assign zero_cnt = req_bus.count == '0;
   assign too_long = FRM_W'(req_bus.count) > (n_ext - rel);

   always_comb begin
      cmd.rel = rel[REL_W-1:0];
      cmd.cnt = req_bus.count;
      unique case (req_bus.mode)
         MODE_ALLOC:   cmd.op = zero_cnt ? OP_REJECT : OP_ALLOC;
         MODE_RELEASE: cmd.op = outside ? OP_REJECT : OP_RELEASE;
         MODE_MARK:    cmd.op = (zero_cnt || outside || too_long) ? OP_REJECT : OP_MARK;
         MODE_CLEAR:   cmd.op = OP_CLEAR;
         default:      cmd.op = OP_REJECT;
      endcase
   end

endmodule

// ===== src/cfa_queue.sv =====
// ----------------------------------------------------------------------------
// cfa_queue: two-entry command queue
// Decouples intake from the engine so each side can stall on its own.
// ----------------------------------------------------------------------------
module cfa_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cfa_pkg::cfa_cmd_type  push_cmd,
   output logic                  q_ready,
   input  logic                  pop,
   output cfa_pkg::cfa_qhead_type head
);
   import cfa_pkg::*;

   cfa_cmd_type entry_ff [2];
   logic [1:0]  fill_ff, fill_in;
   logic        wr_ff, rd_ff;

   assign q_ready    = fill_ff != 2'd2;
   assign head.valid = fill_ff != 2'd0;
   assign head.cmd   = entry_ff[rd_ff];

   always_comb begin
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
      end
      if (push) entry_ff[wr_ff] <= push_cmd;
   end

endmodule

// ===== src/cfa_back.sv =====
// ----------------------------------------------------------------------------
// cfa_back: allocation engine
// Owns the frame state memory and runs scan, mark, release and clear sweeps.
// ----------------------------------------------------------------------------
module cfa_back #(
   parameter int MAX_FRAMES = 16384
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfa_pkg::cfa_qhead_type    head,
   output logic                      pop,
   output logic                      busy,
   input  logic [cfa_pkg::FRM_W-1:0] base_frame,
   input  logic [cfa_pkg::CNT_W-1:0] pool_n,
   input  logic                      clear_trig,
   cfa_rsp_if.source                 rsp_bus
);
   import cfa_pkg::*;

   localparam int ROWS = (MAX_FRAMES + SPR - 1) / SPR;
   localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

   logic [2*SPR-1:0] mem [ROWS];
   logic [2*SPR-1:0] rdata_ff;
   logic [2*SPR-1:0] wdata;
   logic             we;

   cfa_state_type    state_ff, state_in;
   cfa_cmd_type      cmd_ff, cmd_in;
   logic [AW-1:0]    row_ff, row_in;
   logic [1:0]       sub_ff, sub_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [CMP_W-1:0] start_ff, start_in;
   logic [CMP_W-1:0] lo_ff, lo_in;
   logic [CMP_W-1:0] hi_ff, hi_in;
   logic             first_row_ff, first_row_in;
   logic             resp_ff, resp_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [1:0]       status_ff, status_in;
   logic [FRM_W-1:0] first_ff, first_in;
   logic             ovalid_ff, ovalid_in;
   logic [1:0]       ostat_ff, ostat_in;
   logic [FRM_W-1:0] ofirst_ff, ofirst_in;
   logic [CNT_W-1:0] ofree_ff, ofree_in;

   logic [CMP_W-1:0] n17;
   logic [CMP_W-1:0] row_base;
   logic [1:0]       old_s [SPR];

   // scan step
   logic [CNT_W-1:0] sc_run;
   logic [CMP_W-1:0] sc_st;
   logic             sc_hit;
   logic [CMP_W-1:0] sc_idx;
   logic [5:0]       sc_pos;

   // range write
   logic [2*SPR-1:0] wr_new;
   logic [SPR-1:0]   wr_freehit;
   logic [CNT_W-1:0] wr_fcnt;
   logic             wr_done;
   logic [CMP_W-1:0] wr_idx;
   logic             wr_inr;

   // release walk
   logic [4:0]       rl_sp;
   logic [SPR-1:0]   rl_low_mask, rl_head_bit, rl_stop, rl_sm, rl_low, rl_fmask;
   logic [2*SPR-1:0] rl_new;
   logic [CNT_W-1:0] rl_fadd;
   logic             rl_done;
   logic             rl_bad_head;
   logic [CMP_W-1:0] rl_idx;

   assign n17      = CMP_W'(pool_n);
   assign row_base = CMP_W'({row_ff, 5'b0});
   assign busy     = state_ff == S_CLR;

   assign rsp_bus.valid       = ovalid_ff;
   assign rsp_bus.status      = ostat_ff;
   assign rsp_bus.first_frame = ofirst_ff;
   assign rsp_bus.free_count  = ofree_ff;

   always_comb begin
      for (int j = 0; j < SPR; j++) old_s[j] = rdata_ff[2*j +: 2];
   end

   // first-fit over one group of frames of the current row
   always_comb begin
      sc_run = run_ff;
      sc_st  = start_ff;
      sc_hit = 1'b0;
      sc_idx = '0;
      sc_pos = '0;
      for (int k = 0; k < GRP; k++) begin
         sc_pos = {sub_ff, 3'(k), 1'b0};
         sc_idx = row_base + CMP_W'({sub_ff, 3'(k)});
         if (!sc_hit) begin
            if (rdata_ff[sc_pos +: 2] == FS_FREE && sc_idx < n17) begin
               if (sc_run == '0) sc_st = sc_idx;
               sc_run = sc_run + 1'b1;
               if (sc_run == cmd_ff.cnt) sc_hit = 1'b1;
            end else begin
               sc_run = '0;
            end
         end
      end
   end

   // head plus tail over [lo, hi) within the current row
   always_comb begin
      wr_idx = '0;
      wr_inr = 1'b0;
      for (int j = 0; j < SPR; j++) begin
         wr_idx        = row_base + CMP_W'(j);
         wr_inr        = (wr_idx >= lo_ff) && (wr_idx < hi_ff);
         wr_new[2*j +: 2] = wr_inr ? ((wr_idx == lo_ff) ? FS_HEAD : FS_USED) : old_s[j];
         wr_freehit[j] = wr_inr && (old_s[j] == FS_FREE);
      end
      wr_fcnt = CNT_W'($countones(wr_freehit));
      wr_done = (row_base + CMP_W'(SPR)) >= hi_ff;
   end

   // free up to the first free frame, head or pool end
   always_comb begin
      rl_idx = '0;
      rl_sp  = first_row_ff ? lo_ff[4:0] : 5'd0;
      for (int j = 0; j < SPR; j++) begin
         rl_idx     = row_base + CMP_W'(j);
         rl_stop[j] = (old_s[j] == FS_FREE) || (old_s[j] == FS_HEAD) || (rl_idx >= n17);
      end
      rl_low_mask = (SPR'(1) << rl_sp) - SPR'(1);
      rl_head_bit = first_row_ff ? (SPR'(1) << rl_sp) : '0;
      rl_sm       = rl_stop & ~rl_low_mask & ~rl_head_bit;
      rl_low      = rl_sm & (~rl_sm + SPR'(1));
      rl_fmask    = (rl_sm == '0) ? ~rl_low_mask : ((rl_low - SPR'(1)) & ~rl_low_mask);
      for (int j = 0; j < SPR; j++) begin
         rl_new[2*j +: 2] = rl_fmask[j] ? FS_FREE : old_s[j];
      end
      rl_fadd     = CNT_W'($countones(rl_fmask));
      rl_done     = (rl_sm != '0) || (row_ff == LAST_ROW);
      rl_bad_head = first_row_ff && (old_s[rl_sp] != FS_HEAD);
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      sub_in       = sub_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_row_in = first_row_ff;
      resp_in      = resp_ff;
      free_in      = free_ff;
      status_in    = status_ff;
      first_in     = first_ff;
      ovalid_in    = ovalid_ff && !rsp_bus.ready;
      ostat_in     = ostat_ff;
      ofirst_in    = ofirst_ff;
      ofree_in     = ofree_ff;
      pop          = 1'b0;
      we           = 1'b0;
      wdata        = '1;

      unique case (state_ff)
         S_CLR: begin
            we     = 1'b1;
            wdata  = '1;
            row_in = row_ff + 1'b1;
            if (row_ff == LAST_ROW) begin
               free_in   = pool_n;
               status_in = STAT_OK;
               state_in  = resp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            pop = head.valid;
            if (head.valid) begin
               cmd_in   = head.cmd;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            first_in = '0;
            unique case (cmd_ff.op)
               OP_ALLOC: begin
                  row_in   = '0;
                  run_in   = '0;
                  state_in = S_A_RD;
               end
               OP_RELEASE: begin
                  lo_in        = CMP_W'(cmd_ff.rel);
                  row_in       = cmd_ff.rel[5 +: AW];
                  first_row_in = 1'b1;
                  state_in     = S_R_RD;
               end
               OP_MARK: begin
                  lo_in    = CMP_W'(cmd_ff.rel);
                  hi_in    = CMP_W'(cmd_ff.rel) + CMP_W'(cmd_ff.cnt);
                  row_in   = cmd_ff.rel[5 +: AW];
                  state_in = S_W_RD;
               end
               OP_CLEAR: begin
                  resp_in  = 1'b1;
                  row_in   = '0;
                  state_in = S_CLR;
               end
               default: begin
                  status_in = STAT_RANGE;
                  state_in  = S_DONE;
               end
            endcase
         end
         S_A_RD: begin
            sub_in = '0;
            if (row_base >= n17) begin
               status_in = STAT_NORUN;
               state_in  = S_DONE;
            end else begin
               state_in = S_A_SCAN;
            end
         end
         S_A_SCAN: begin
            run_in   = sc_run;
            start_in = sc_st;
            sub_in   = sub_ff + 1'b1;
            if (sc_hit) begin
               lo_in    = sc_st;
               hi_in    = sc_st + CMP_W'(cmd_ff.cnt);
               row_in   = sc_st[5 +: AW];
               state_in = S_W_RD;
            end else if (sub_ff == 2'd3) begin
               if (row_ff == LAST_ROW) begin
                  status_in = STAT_NORUN;
                  state_in  = S_DONE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_A_RD;
               end
            end
         end
         S_W_RD: state_in = S_W_WR;
         S_W_WR: begin
            we      = 1'b1;
            wdata   = wr_new;
            free_in = (free_ff >= wr_fcnt) ? (free_ff - wr_fcnt) : '0;
            if (wr_done) begin
               status_in = STAT_OK;
               first_in  = (cmd_ff.op == OP_ALLOC) ? (base_frame + FRM_W'(lo_ff)) : '0;
               state_in  = S_DONE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_W_RD;
            end
         end
         S_R_RD: state_in = S_R_CHK;
         S_R_CHK: begin
            if (rl_bad_head) begin
               status_in = STAT_NOTHEAD;
               state_in  = S_DONE;
            end else begin
               we           = 1'b1;
               wdata        = rl_new;
               free_in      = free_ff + rl_fadd;
               first_row_in = 1'b0;
               if (rl_done) begin
                  status_in = STAT_OK;
                  state_in  = S_DONE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_R_RD;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!ovalid_ff || rsp_bus.ready) begin
               ovalid_in = 1'b1;
               ostat_in  = status_ff;
               ofirst_in = first_ff;
               ofree_in  = free_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // pool resize restarts the sweep
      if (clear_trig) begin
         state_in = S_CLR;
         row_in   = '0;
         resp_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         row_ff    <= '0;
         resp_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         resp_ff   <= resp_in;
         ovalid_ff <= ovalid_in;
      end
      cmd_ff       <= cmd_in;
      sub_ff       <= sub_in;
      run_ff       <= run_in;
      start_ff     <= start_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      first_row_ff <= first_row_in;
      free_ff      <= free_in;
      status_ff    <= status_in;
      first_ff     <= first_in;
      ostat_ff     <= ostat_in;
      ofirst_ff    <= ofirst_in;
      ofree_ff     <= ofree_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[row_ff] <= wdata;
      rdata_ff <= mem[row_ff];
   end

   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !pop)
      else $error("command taken during clearing sweep");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && ostat_ff != STAT_OK) |-> (ofirst_ff == '0))
      else $error("nonzero first frame on failed command");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(ovalid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

endmodule
